// ----- hdl/sqr_pkg.sv -----
`default_nettype none
package sqr_pkg;

    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BTICK  = 8'h60;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_STRING = 2'd1,
        MODE_IDENT  = 2'd2,
        MODE_QSEEN  = 2'd3
    } t_mode;

    typedef enum logic {
        FUNC_BYTE = 1'b0,
        FUNC_END  = 1'b1
    } t_func;

    // One queued command: one or two results.
    typedef struct packed {
        logic [7:0] byte0;
        logic       has0;
        logic [7:0] byte1;
        logic       two;
        logic       text_end;
        logic       unterminated;
    } t_cmd;

    // Byte as handled outside any quote.
    function automatic logic [7:0] normal_out(input logic [7:0] b);
        normal_out = (b == CH_DQUOTE) ? CH_BTICK : b;
    endfunction

    function automatic t_mode normal_next(input logic [7:0] b);
        if (b == CH_SQUOTE) begin
            normal_next = MODE_STRING;
        end else if (b == CH_DQUOTE) begin
            normal_next = MODE_IDENT;
        end else begin
            normal_next = MODE_NORMAL;
        end
    endfunction

endpackage
`default_nettype wire

// ----- hdl/sqr_if.sv -----
`default_nettype none
interface sqr_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] in_byte;

    modport source (output valid, output func, output in_byte, input ready);
    modport sink (input valid, input func, input in_byte, output ready);
endinterface

interface sqr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       run_last;
    logic       text_end;
    logic       unterminated;

    modport source (output valid, output out_byte, output has_byte, output run_last,
                    output text_end, output unterminated, input ready);
    modport sink (input valid, input out_byte, input has_byte, input run_last,
                  input text_end, input unterminated, output ready);
endinterface
`default_nettype wire

// ----- hdl/sqr_front.sv -----
`default_nettype none
module sqr_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    sqr_in_if.sink           i_req,
    input  wire logic        i_full,
    output sqr_pkg::t_cmd    o_cmd,
    output logic             o_push
);
    import sqr_pkg::*;

    t_mode r_mode;
    t_mode n_mode;
    logic  emit;
    logic  accept;

    assign i_req.ready = !i_full;
    assign accept      = i_req.valid && !i_full;
    assign o_push      = accept && emit;

    always_comb begin
        n_mode             = r_mode;
        emit               = 1'b1;
        o_cmd.byte0        = i_req.in_byte;
        o_cmd.has0         = 1'b1;
        o_cmd.byte1        = CH_BTICK;
        o_cmd.two          = 1'b0;
        o_cmd.text_end     = 1'b0;
        o_cmd.unterminated = 1'b0;
        if (i_req.func == FUNC_END) begin
            n_mode             = MODE_NORMAL;
            o_cmd.byte0        = (r_mode == MODE_QSEEN) ? CH_BTICK : 8'd0;
            o_cmd.has0         = (r_mode == MODE_QSEEN);
            o_cmd.text_end     = 1'b1;
            o_cmd.unterminated = (r_mode == MODE_IDENT);
        end else begin
            unique case (r_mode)
                MODE_STRING: begin
                    if (i_req.in_byte == CH_SQUOTE) begin
                        n_mode = MODE_NORMAL;
                    end
                end
                MODE_IDENT: begin
                    if (i_req.in_byte == CH_DQUOTE) begin
                        // closing or escaped quote: decided on the next byte
                        emit   = 1'b0;
                        n_mode = MODE_QSEEN;
                    end else if (i_req.in_byte == CH_BTICK) begin
                        o_cmd.two = 1'b1;
                    end
                end
                MODE_QSEEN: begin
                    if (i_req.in_byte == CH_DQUOTE) begin
                        n_mode = MODE_IDENT;
                    end else begin
                        o_cmd.byte0 = CH_BTICK;
                        o_cmd.byte1 = normal_out(i_req.in_byte);
                        o_cmd.two   = 1'b1;
                        n_mode      = normal_next(i_req.in_byte);
                    end
                end
                default: begin
                    o_cmd.byte0 = normal_out(i_req.in_byte);
                    n_mode      = normal_next(i_req.in_byte);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
        end else if (accept) begin
            r_mode <= n_mode;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/sqr_fifo.sv -----
`default_nettype none
module sqr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_full,
    output logic                  o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [AW:0]      r_count;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        bump = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= bump(r_wr);
            end
            if (i_pop) begin
                r_rd <= bump(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- hdl/sqr_back.sv -----
`default_nettype none
module sqr_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire sqr_pkg::t_cmd i_cmd,
    input  wire logic          i_empty,
    output logic               o_pop,
    sqr_out_if.source          o_res
);
    import sqr_pkg::*;

    logic r_second;
    logic take;

    assign o_res.valid        = !i_empty;
    assign o_res.out_byte     = r_second ? i_cmd.byte1 : i_cmd.byte0;
    assign o_res.has_byte     = r_second || i_cmd.has0;
    assign o_res.run_last     = !i_cmd.two || r_second;
    assign o_res.text_end     = i_cmd.text_end;
    assign o_res.unterminated = i_cmd.unterminated;

    assign take  = o_res.valid && o_res.ready;
    assign o_pop = take && (!i_cmd.two || r_second);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second <= 1'b0;
        end else if (take) begin
            r_second <= i_cmd.two && !r_second;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/sql_identifier_quote_rewriter.sv -----
// A result is registered in the queue and offered when it reaches the queue head.
// Up to one request per cycle while the queue is not full; a request with two
// results occupies the output for both, and the four-entry queue absorbs that until full.
// A double quote inside an identifier yields no result of its own; the next byte decides.
// Synchronous active-low reset: mode returns to normal text, queue empties.
`default_nettype none
module sql_identifier_quote_rewriter #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sqr_in_if.sink    i_req,
    sqr_out_if.source o_res
);
    import sqr_pkg::*;

    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic full;
    logic empty;

    sqr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_full  (full),
        .o_cmd   (push_cmd),
        .o_push  (push)
    );

    sqr_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .i_pop   (pop),
        .o_data  (head_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    sqr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (head_cmd),
        .i_empty (empty),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule
`default_nettype wire

// ----- hdl/sqr_checker.sv -----
`default_nettype none
module sqr_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       i_ready,
    input wire logic [7:0] i_out_byte,
    input wire logic       i_has_byte,
    input wire logic       i_run_last,
    input wire logic       i_text_end,
    input wire logic       i_unterminated
);

    // an open identifier is only reported at end of text, with no byte
    a_unterm_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_unterminated |-> i_text_end && !i_has_byte)
        else $error("unterminated flag outside end-of-text result");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_text_end |-> i_run_last)
        else $error("end-of-text result not last of its request");

    a_empty_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_has_byte |-> i_text_end && i_out_byte == 8'd0)
        else $error("byte-less result outside end of text");

    // first half of a pair is always followed by its partner
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && !i_run_last |=> i_valid && i_has_byte && !i_text_end)
        else $error("second result of a pair missing");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_out_byte) && $stable(i_run_last))
        else $error("stalled result changed");

endmodule

bind sql_identifier_quote_rewriter sqr_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_res.valid),
    .i_ready        (o_res.ready),
    .i_out_byte     (o_res.out_byte),
    .i_has_byte     (o_res.has_byte),
    .i_run_last     (o_res.run_last),
    .i_text_end     (o_res.text_end),
    .i_unterminated (o_res.unterminated)
);
`default_nettype wire

// ----- bench/sql_identifier_quote_rewriter_test.sv -----
`default_nettype none
module sql_identifier_quote_rewriter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sqr_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 900;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned LIMIT_CYCLES = 200000;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       run_last;
        logic       text_end;
        logic       unterminated;
    } t_rewrite;

    // Tracks the quoting mode and queues the bytes the rewriter owes us.
    class quote_rewrite_board;
        t_mode       mode;
        t_rewrite    pending_out[$];
        int unsigned errors;
        int unsigned checked;

        function new();
            mode    = MODE_NORMAL;
            errors  = 0;
            checked = 0;
        endfunction

        function void push_out(logic [7:0] b, logic has, logic last, logic fin, logic unt);
            pending_out.push_back('{out_byte: b, has_byte: has, run_last: last,
                                    text_end: fin, unterminated: unt});
        endfunction

        // Byte outside any quote
        function void plain_byte(logic [7:0] b);
            if (b == CH_SQUOTE) begin
                mode = MODE_STRING;
            end else if (b == CH_DQUOTE) begin
                mode = MODE_IDENT;
                b    = CH_BTICK;
            end
            push_out(b, 1'b1, 1'b1, 1'b0, 1'b0);
        endfunction

        function void note_request(t_func f, logic [7:0] b);
            if (f == FUNC_END) begin
                case (mode)
                    MODE_QSEEN: push_out(CH_BTICK, 1'b1, 1'b1, 1'b1, 1'b0);
                    MODE_IDENT: push_out(8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
                    default:    push_out(8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
                endcase
                mode = MODE_NORMAL;
                return;
            end
            case (mode)
                MODE_STRING: begin
                    if (b == CH_SQUOTE) mode = MODE_NORMAL;
                    push_out(b, 1'b1, 1'b1, 1'b0, 1'b0);
                end
                MODE_IDENT: begin
                    if (b == CH_DQUOTE) begin
                        mode = MODE_QSEEN;   // closing backtick waits for the next byte
                    end else if (b == CH_BTICK) begin
                        push_out(CH_BTICK, 1'b1, 1'b0, 1'b0, 1'b0);
                        push_out(CH_BTICK, 1'b1, 1'b1, 1'b0, 1'b0);
                    end else begin
                        push_out(b, 1'b1, 1'b1, 1'b0, 1'b0);
                    end
                end
                MODE_QSEEN: begin
                    if (b == CH_DQUOTE) begin
                        mode = MODE_IDENT;
                        push_out(CH_DQUOTE, 1'b1, 1'b1, 1'b0, 1'b0);
                    end else begin
                        mode = MODE_NORMAL;
                        push_out(CH_BTICK, 1'b1, 1'b0, 1'b0, 1'b0);
                        plain_byte(b);
                    end
                end
                default: plain_byte(b);
            endcase
        endfunction

        function void report(string what, int unsigned got, int unsigned want);
            $display("mismatch on result %0d: %s got %0h, want %0h", checked, what, got, want);
            errors++;
        endfunction

        function void check_result(t_rewrite got);
            t_rewrite want;
            checked++;
            if (pending_out.size() == 0) begin
                report("unexpected result, out_byte", got.out_byte, 0);
                return;
            end
            want = pending_out.pop_front();
            if (got.out_byte !== want.out_byte)
                report("out_byte", got.out_byte, want.out_byte);
            if (got.has_byte !== want.has_byte)
                report("has_byte", got.has_byte, want.has_byte);
            if (got.run_last !== want.run_last)
                report("run_last", got.run_last, want.run_last);
            if (got.text_end !== want.text_end)
                report("text_end", got.text_end, want.text_end);
            if (got.unterminated !== want.unterminated)
                report("unterminated", got.unterminated, want.unterminated);
        endfunction

        function int unsigned pending();
            return pending_out.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    bit          idle_on     = 1'b1;
    bit          calm        = 1'b0;
    bit          hold_req    = 1'b0;
    bit          held        = 1'b0;
    bit          drained     = 1'b0;
    int unsigned sent        = 0;
    int unsigned cycle_count = 0;

    quote_rewrite_board rewrites = new();

    sqr_in_if  req_if ();
    sqr_out_if res_if ();

    sql_identifier_quote_rewriter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("** sql_identifier_quote_rewriter: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && req_if.valid && req_if.ready)
            rewrites.note_request(t_func'(req_if.func), req_if.in_byte);
        if (i_rst_n && res_if.valid && res_if.ready)
            rewrites.check_result({res_if.out_byte, res_if.has_byte, res_if.run_last,
                                   res_if.text_end, res_if.unterminated});
    end

    // Output side: random stalls, plus one long hold-off on request
    initial begin
        res_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    task automatic send_req(t_func f, logic [7:0] b);
        int unsigned gap;
        gap = 0;
        if (idle_on && !calm && !hold_req && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 13);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.func    <= f;
        req_if.in_byte <= b;
        do @(posedge i_clk); while (!req_if.ready);
        sent++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_req(FUNC_BYTE, b);
    endtask

    task automatic send_end();
        send_req(FUNC_END, 8'($urandom_range(0, 255)));
    endtask

    // Mostly printable text, now and then any byte value
    function automatic logic [7:0] pick_byte(logic [7:0] no_a, logic [7:0] no_b);
        logic [7:0] b;
        do begin
            if ($urandom_range(0, 3) != 0) b = 8'($urandom_range(8'h20, 8'h7e));
            else b = 8'($urandom_range(0, 255));
        end while (b == no_a || b == no_b);
        return b;
    endfunction

    task automatic send_fragment();
        int unsigned kind;
        int unsigned n;
        kind = $urandom_range(0, 99);
        if (kind < 25) begin
            n = $urandom_range(1, 6);
            repeat (n) send_byte(pick_byte(CH_SQUOTE, CH_DQUOTE));
        end else if (kind < 45) begin
            send_byte(CH_SQUOTE);
            n = $urandom_range(0, 8);
            repeat (n) begin
                if ($urandom_range(0, 5) == 0) begin
                    send_byte(CH_SQUOTE);
                    send_byte(CH_SQUOTE);
                end else begin
                    send_byte(pick_byte(CH_SQUOTE, CH_SQUOTE));
                end
            end
            send_byte(CH_SQUOTE);
        end else if (kind < 75) begin
            send_byte(CH_DQUOTE);
            n = $urandom_range(0, 8);
            repeat (n) begin
                case ($urandom_range(0, 7))
                    0: begin
                        send_byte(CH_DQUOTE);
                        send_byte(CH_DQUOTE);
                    end
                    1: send_byte(CH_BTICK);
                    default: send_byte(pick_byte(CH_DQUOTE, CH_DQUOTE));
                endcase
            end
            send_byte(CH_DQUOTE);
        end else if (kind < 83) begin
            send_end();
        end else if (kind < 93) begin
            n = $urandom_range(1, 4);
            repeat (n) send_byte(8'($urandom_range(0, 255)));
        end else begin
            // text cut off inside a quote
            send_byte($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE);
            n = $urandom_range(0, 3);
            repeat (n) send_byte(pick_byte(CH_SQUOTE, CH_DQUOTE));
            send_end();
        end
    endtask

    initial begin
        req_if.valid   <= 1'b0;
        req_if.func    <= FUNC_BYTE;
        req_if.in_byte <= 8'h00;
        i_rst_n        <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // plain text, field extremes, end in normal mode
        send_byte(8'h00);
        send_byte(8'hff);
        send_req(FUNC_END, 8'hff);
        // string literal with a doubled quote, ended while still open
        send_byte(CH_SQUOTE);
        send_byte(CH_DQUOTE);
        send_byte(CH_SQUOTE);
        send_byte(CH_SQUOTE);
        send_byte(CH_BTICK);
        send_req(FUNC_END, 8'h00);
        // identifier: backtick doubled, doubled double quote, close then quote
        send_byte(CH_DQUOTE);
        send_byte(CH_BTICK);
        send_byte(CH_DQUOTE);
        send_byte(CH_DQUOTE);
        send_byte(8'hff);
        send_byte(CH_DQUOTE);
        send_byte(CH_SQUOTE);
        send_byte(CH_SQUOTE);
        // end right after the closing quote
        send_byte(CH_DQUOTE);
        send_byte(CH_DQUOTE);
        send_end();
        // identifier left open at end
        send_byte(CH_DQUOTE);
        send_byte(8'h41);
        send_end();
        // close then plain byte
        send_byte(CH_DQUOTE);
        send_byte(CH_DQUOTE);
        send_byte(8'h00);

        while (sent < 26 + RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 3) == 0);
            if (!held && sent >= 300) begin
                held     = 1'b1;
                hold_req = 1'b1;
                repeat (40) send_byte(pick_byte(CH_SQUOTE, CH_DQUOTE));
            end
            if (!drained && sent >= 600) begin
                drained = 1'b1;
                req_if.valid <= 1'b0;
                do @(posedge i_clk); while (rewrites.pending() != 0);
                repeat (40) send_fragment();
            end
            if (sent >= 26 + RANDOM_ITEMS - 150)
                idle_on = 1'b0;
            send_fragment();
        end

        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (rewrites.pending() != 0);
        repeat (10) @(posedge i_clk);
        if (rewrites.errors == 0) begin
            $display("** sql_identifier_quote_rewriter: PASSED **");
        end else begin
            $display("** sql_identifier_quote_rewriter: FAILED **");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ----- files.f -----
hdl/sqr_pkg.sv
hdl/sqr_if.sv
hdl/sqr_front.sv
hdl/sqr_fifo.sv
hdl/sqr_back.sv
hdl/sql_identifier_quote_rewriter.sv
hdl/sqr_checker.sv
bench/sql_identifier_quote_rewriter_test.sv
